// ===== rtl/lge_pkg.sv =====
// Shared constants, command codes and control structs of the life generation engine.
package lge_pkg;

    localparam int MaxColumns = 64;
    localparam int MaxRows    = 64;
    localparam int ColW       = 6;
    localparam int RowW       = 6;
    localparam int SizeW      = 7;

    localparam logic [1:0] FUNC_WRITE   = 2'd0;
    localparam logic [1:0] FUNC_READ    = 2'd1;
    localparam logic [1:0] FUNC_ADVANCE = 2'd2;
    localparam logic [1:0] FUNC_CLEAR   = 2'd3;

    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    localparam logic [3:0] OP_NOP      = 4'd0;
    localparam logic [3:0] OP_LATCH    = 4'd1;
    localparam logic [3:0] OP_CELL     = 4'd2;
    localparam logic [3:0] OP_CLEAR    = 4'd3;
    localparam logic [3:0] OP_RD_LAST  = 4'd4;
    localparam logic [3:0] OP_RD_FIRST = 4'd5;
    localparam logic [3:0] OP_RD_SECND = 4'd6;
    localparam logic [3:0] OP_CAP_NEXT = 4'd7;
    localparam logic [3:0] OP_GEN_CELL = 4'd8;
    localparam logic [3:0] OP_WR_ROW   = 4'd9;
    localparam logic [3:0] OP_LOAD_OUT = 4'd10;

    typedef struct packed {
        logic [3:0] op;
    } t_cmd;

    typedef struct packed {
        logic       col_last;
        logic       row_last;
    } t_status;

endpackage

// ===== rtl/lge_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lge_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/lge_ctrl.sv =====
// Sequencer of the life generation engine: request handshakes and datapath commands.
module lge_ctrl
    import lge_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic [1:0] i_func,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CELL  = 4'd1;
    localparam logic [3:0] S_CLR   = 4'd2;
    localparam logic [3:0] S_A0    = 4'd3;
    localparam logic [3:0] S_A1    = 4'd4;
    localparam logic [3:0] S_A2    = 4'd5;
    localparam logic [3:0] S_A3    = 4'd6;
    localparam logic [3:0] S_ACELL = 4'd7;
    localparam logic [3:0] S_AWR   = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_valid, n_valid;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        n_state  = r_state;
        n_valid  = r_valid && !i_ready;
        o_cmd.op = OP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LATCH;
                    case (i_func)
                        FUNC_WRITE, FUNC_READ: n_state = S_CELL;
                        FUNC_ADVANCE:          n_state = S_A0;
                        default:               n_state = S_CLR;
                    endcase
                end
            end
            S_CELL: begin
                o_cmd.op = OP_CELL;
                n_state  = S_FIN;
            end
            S_CLR: begin
                o_cmd.op = OP_CLEAR;
                n_state  = S_FIN;
            end
            S_A0: begin
                o_cmd.op = OP_RD_LAST;
                n_state  = S_A1;
            end
            S_A1: begin
                o_cmd.op = OP_RD_FIRST;
                n_state  = S_A2;
            end
            S_A2: begin
                o_cmd.op = OP_RD_SECND;
                n_state  = S_A3;
            end
            S_A3: begin
                o_cmd.op = OP_CAP_NEXT;
                n_state  = S_ACELL;
            end
            S_ACELL: begin
                o_cmd.op = OP_GEN_CELL;
                if (i_status.col_last) begin
                    n_state = S_AWR;
                end
            end
            S_AWR: begin
                o_cmd.op = OP_WR_ROW;
                n_state  = i_status.row_last ? S_FIN : S_A3;
            end
            S_FIN: begin
                if (!r_valid || i_ready) begin
                    o_cmd.op = OP_LOAD_OUT;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

endmodule

// ===== rtl/lge_dp.sv =====
// Datapath of the life generation engine: board rows, row buffers and the cell rule.
module lge_dp
    import lge_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_index,
    input  logic [SizeW-1:0] i_cfg_data,
    input  logic [1:0]       i_func,
    input  logic [ColW-1:0]  i_col,
    input  logic [RowW-1:0]  i_row,
    input  logic             i_new_value,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    output logic             o_cell_value,
    output logic             o_in_range
);

    logic [SizeW-1:0]      r_cfg_cols, r_cfg_rows;
    logic [SizeW-1:0]      nc, nr;
    logic [MaxRows-1:0]    r_row_vld;
    logic                  r_rd_vld;
    logic [MaxColumns-1:0] ram_q, rd_data;
    logic                  we;
    logic [RowW-1:0]       waddr, raddr;
    logic [MaxColumns-1:0] wdata;

    logic [1:0]            r_func;
    logic [ColW-1:0]       r_col;
    logic [RowW-1:0]       r_row;
    logic                  r_val;
    logic                  r_res_cell, r_res_rng;

    logic [MaxColumns-1:0] r_prev, r_cur, r_next, r_new, r_save;
    logic [ColW-1:0]       r_cc;
    logic [RowW-1:0]       r_rr;
    logic                  r_use_save;

    logic                  in_board;
    logic [ColW-1:0]       cl, cr;
    logic [3:0]            nsum;
    logic                  nv;
    logic [SizeW-1:0]      rr_plus2;

    always_comb begin
        nc = (r_cfg_cols < SizeW'(3)) ? SizeW'(3) :
             (r_cfg_cols > SizeW'(MaxColumns)) ? SizeW'(MaxColumns) : r_cfg_cols;
        nr = (r_cfg_rows < SizeW'(3)) ? SizeW'(3) :
             (r_cfg_rows > SizeW'(MaxRows)) ? SizeW'(MaxRows) : r_cfg_rows;
    end

    assign rd_data  = r_rd_vld ? ram_q : '0;
    assign in_board = ({1'b0, r_col} < nc) && ({1'b0, r_row} < nr);

    // Neighbor columns wrap around the active width.
    assign cl = (r_cc == '0) ? ColW'(nc - SizeW'(1)) : r_cc - ColW'(1);
    assign cr = ({1'b0, r_cc} + SizeW'(1) == nc) ? '0 : r_cc + ColW'(1);
    assign nsum = 4'(r_prev[cl]) + 4'(r_prev[r_cc]) + 4'(r_prev[cr])
                + 4'(r_cur[cl]) + 4'(r_cur[cr])
                + 4'(r_next[cl]) + 4'(r_next[r_cc]) + 4'(r_next[cr]);
    assign nv = r_cur[r_cc] ? (nsum == 4'd2 || nsum == 4'd3) : (nsum == 4'd3);
    assign rr_plus2 = {1'b0, r_rr} + SizeW'(2);

    assign o_status.col_last = ({1'b0, r_cc} == nc - SizeW'(1));
    assign o_status.row_last = ({1'b0, r_rr} == nr - SizeW'(1));

    always_comb begin
        we    = 1'b0;
        waddr = r_row;
        wdata = rd_data;
        raddr = r_row;
        case (i_cmd.op)
            OP_LATCH:    raddr = i_row;
            OP_CELL: begin
                we           = (r_func == FUNC_WRITE) && in_board;
                wdata[r_col] = r_val;
            end
            OP_RD_LAST:  raddr = RowW'(nr - SizeW'(1));
            OP_RD_FIRST: raddr = '0;
            OP_RD_SECND: raddr = RowW'(1);
            OP_WR_ROW: begin
                we    = 1'b1;
                waddr = r_rr;
                wdata = r_new;
                raddr = RowW'(rr_plus2);
            end
            default: ;
        endcase
    end

    lge_ram #(.WIDTH(MaxColumns), .DEPTH(MaxRows)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= SizeW'(MaxColumns);
            r_cfg_rows <= SizeW'(MaxRows);
            r_row_vld  <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_COLUMNS) begin
                    r_cfg_cols <= i_cfg_data;
                end else begin
                    r_cfg_rows <= i_cfg_data;
                end
            end
            if (i_cmd.op == OP_CLEAR) begin
                r_row_vld <= '0;
            end else if (we) begin
                r_row_vld[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_row_vld[raddr];
        case (i_cmd.op)
            OP_LATCH: begin
                r_func <= i_func;
                r_col  <= i_col;
                r_row  <= i_row;
                r_val  <= i_new_value;
            end
            OP_CELL: begin
                r_res_cell <= (r_func == FUNC_READ) && in_board && rd_data[r_col];
                r_res_rng  <= in_board;
            end
            OP_CLEAR: begin
                r_res_cell <= 1'b0;
                r_res_rng  <= 1'b0;
            end
            OP_RD_LAST: begin
                r_res_cell <= 1'b0;
                r_res_rng  <= 1'b0;
                r_rr       <= '0;
            end
            OP_RD_FIRST: r_prev <= rd_data;
            OP_RD_SECND: begin
                r_cur      <= rd_data;
                r_new      <= rd_data;
                r_save     <= rd_data;
                r_use_save <= 1'b0;
            end
            OP_CAP_NEXT: begin
                // The row below the last one is the old top row, kept aside.
                r_next <= r_use_save ? r_save : rd_data;
                r_cc   <= '0;
            end
            OP_GEN_CELL: begin
                r_new[r_cc] <= nv;
                r_cc        <= r_cc + ColW'(1);
            end
            OP_WR_ROW: begin
                r_prev     <= r_cur;
                r_cur      <= r_next;
                r_new      <= r_next;
                r_rr       <= r_rr + RowW'(1);
                r_use_save <= (rr_plus2 == nr);
            end
            OP_LOAD_OUT: begin
                o_cell_value <= r_res_cell;
                o_in_range   <= r_res_rng;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/life_generation_engine.sv =====
// Top level of the life generation engine: toroidal Conway board with cell access.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+---------------------------------------
//  input   | i_valid     | o_ready     | i_func, i_col, i_row, i_new_value
//  result  | o_valid     | i_ready     | o_cell_value, o_in_range
//  config  | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// An advance is paced by the one-cell-per-cycle rule unit and the single row
// read port of the board memory. One request is worked on at a time. Reset
// clears the per-row valid bits at once, so the board reads dead without a
// clearing pass. A result waiting in the output register holds the next
// request only at its final step.
module life_generation_engine
    import lge_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_func,
    input  logic [ColW-1:0]  i_col,
    input  logic [RowW-1:0]  i_row,
    input  logic             i_new_value,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_cell_value,
    output logic             o_in_range,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [SizeW-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    lge_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_func   (i_func),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    lge_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_func       (i_func),
        .i_col        (i_col),
        .i_row        (i_row),
        .i_new_value  (i_new_value),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_cell_value (o_cell_value),
        .o_in_range   (o_in_range)
    );

endmodule
